// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define TSA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsa assertion failed");

// Condition that must never hold
`define TSA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tsa forbidden condition seen");

`endif

// ===== rtl/core/tsa_pkg.sv =====
// Types, constants and helpers for the terrain slope angle core
package tsa_pkg;

    localparam int NMAG_W   = 32;   // magnitude word ahead of normalization
    localparam int NORM_W   = 30;   // normalized magnitude, top bit at 29
    localparam int NORM_MSB = 29;
    localparam int SD_W     = 16;
    localparam int UX_W     = SD_W + 1;
    localparam int XS_W     = UX_W + NORM_MSB;
    localparam int SQR_W    = 2 * NORM_W;
    localparam int SUM_W    = SQR_W + 1;
    localparam int SQ_W     = SUM_W + 1;
    localparam int ROOT_W   = 31;
    localparam int CW       = 60;
    localparam int ZW       = 32;
    localparam int ALIGN_MSB = 56;
    localparam int ANGLE_W  = 15;
    localparam int ATAN_LEN = 24;

    localparam logic [SD_W-1:0]    SD_RESET  = 16'd256;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 15'd25736;

    localparam logic [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
        32'h3243F6A9, 32'h1DAC6705, 32'h0FADBAFD, 32'h07F56EA7, 32'h03FEAB77,
        32'h01FFD55C, 32'h00FFFAAB, 32'h007FFF55, 32'h003FFFEB, 32'h001FFFFD,
        32'h00100000, 32'h00080000, 32'h00040000, 32'h00020000, 32'h00010000,
        32'h00008000, 32'h00004000, 32'h00002000, 32'h00001000, 32'h00000800,
        32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080
    };

    typedef struct packed {
        logic              flat;
        logic [XS_W-1:0]   sx;
        logic [SUM_W-1:0]  sum;
    } front_t;

    typedef struct packed {
        logic              flat;
        logic [XS_W-1:0]   sx;
        logic [SQ_W-1:0]   n;
        logic [SQ_W-1:0]   res;
    } sq_t;

    typedef struct packed {
        logic                 flat;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cr_t;

    // index of the highest set bit, zero for an all-zero word
    function automatic logic [5:0] lead_one(input logic [63:0] v);
        logic [5:0] msb;
        msb = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                msb = 6'(i);
        end
        return msb;
    endfunction

endpackage

// ===== rtl/core/tsa_front.sv =====
// Front end: central differences, magnitude normalization and sum of squares
module tsa_front #(
    parameter int HEIGHT_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vld_in,
    input  logic signed [HEIGHT_BITS-1:0] height_left,
    input  logic signed [HEIGHT_BITS-1:0] height_right,
    input  logic signed [HEIGHT_BITS-1:0] height_down,
    input  logic signed [HEIGHT_BITS-1:0] height_up,
    input  logic [tsa_pkg::SD_W-1:0]      sample_distance,
    output logic                          vld_out,
    output tsa_pkg::front_t               dout
);
    import tsa_pkg::*;

    logic signed [HEIGHT_BITS:0] diff_a, diff_b, neg_a, neg_b;
    logic [HEIGHT_BITS-1:0]      mag_a, mag_b;

    logic [HEIGHT_BITS-1:0] s1_ua_reg, s1_ub_reg;
    logic [UX_W-1:0]        s1_ux_reg;
    logic                   s1_vld_reg;

    logic [NMAG_W-1:0] ua_ext, ub_ext;
    logic [4:0]        msb_next;
    logic [NMAG_W-1:0] s2_ua_reg, s2_ub_reg;
    logic [UX_W-1:0]   s2_ux_reg;
    logic [4:0]        s2_msb_reg;
    logic              s2_flat_reg, s2_vld_reg;

    logic [4:0]        rs, ls;
    logic [NORM_W-1:0] na_next, nb_next;
    logic [XS_W-1:0]   sx_next;
    logic [NORM_W-1:0] s3_na_reg, s3_nb_reg;
    logic [XS_W-1:0]   s3_sx_reg;
    logic              s3_flat_reg, s3_vld_reg;

    logic [SQR_W-1:0]  s4_sqa_reg, s4_sqb_reg;
    logic [XS_W-1:0]   s4_sx_reg;
    logic              s4_flat_reg, s4_vld_reg;

    logic [SUM_W-1:0]  s5_sum_reg;
    logic [XS_W-1:0]   s5_sx_reg;
    logic              s5_flat_reg, s5_vld_reg;

    always_comb
    begin
        diff_a = $signed({height_right[HEIGHT_BITS-1], height_right})
               - $signed({height_left[HEIGHT_BITS-1], height_left});
        diff_b = $signed({height_up[HEIGHT_BITS-1], height_up})
               - $signed({height_down[HEIGHT_BITS-1], height_down});
        neg_a  = -diff_a;
        neg_b  = -diff_b;
        mag_a  = diff_a[HEIGHT_BITS] ? neg_a[HEIGHT_BITS-1:0] : diff_a[HEIGHT_BITS-1:0];
        mag_b  = diff_b[HEIGHT_BITS] ? neg_b[HEIGHT_BITS-1:0] : diff_b[HEIGHT_BITS-1:0];
    end

    always_comb
    begin
        ua_ext   = NMAG_W'(s1_ua_reg);
        ub_ext   = NMAG_W'(s1_ub_reg);
        msb_next = 5'(lead_one(64'(ua_ext | ub_ext)));
    end

    // scale so the larger magnitude has its top bit at NORM_MSB; spacing follows
    always_comb
    begin
        rs = s2_msb_reg - 5'(NORM_MSB);
        ls = 5'(NORM_MSB) - s2_msb_reg;
        if (s2_msb_reg > 5'(NORM_MSB))
        begin
            na_next = NORM_W'(s2_ua_reg >> rs);
            nb_next = NORM_W'(s2_ub_reg >> rs);
            sx_next = XS_W'(s2_ux_reg >> rs);
        end
        else
        begin
            na_next = NORM_W'(s2_ua_reg << ls);
            nb_next = NORM_W'(s2_ub_reg << ls);
            sx_next = XS_W'(s2_ux_reg) << ls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= vld_in;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ua_reg   <= mag_a;
            s1_ub_reg   <= mag_b;
            s1_ux_reg   <= {sample_distance, 1'b0};

            s2_ua_reg   <= ua_ext;
            s2_ub_reg   <= ub_ext;
            s2_ux_reg   <= s1_ux_reg;
            s2_msb_reg  <= msb_next;
            s2_flat_reg <= ((ua_ext | ub_ext) == '0);

            s3_na_reg   <= na_next;
            s3_nb_reg   <= nb_next;
            s3_sx_reg   <= sx_next;
            s3_flat_reg <= s2_flat_reg;

            s4_sqa_reg  <= s3_na_reg * s3_na_reg;
            s4_sqb_reg  <= s3_nb_reg * s3_nb_reg;
            s4_sx_reg   <= s3_sx_reg;
            s4_flat_reg <= s3_flat_reg;

            s5_sum_reg  <= SUM_W'(s4_sqa_reg) + SUM_W'(s4_sqb_reg);
            s5_sx_reg   <= s4_sx_reg;
            s5_flat_reg <= s4_flat_reg;
        end
    end

    assign vld_out   = s5_vld_reg;
    assign dout.flat = s5_flat_reg;
    assign dout.sx   = s5_sx_reg;
    assign dout.sum  = s5_sum_reg;

endmodule

// ===== rtl/core/tsa_sqrt_cell.sv =====
// One result bit of the digit-by-digit integer square root
module tsa_sqrt_cell #(
    parameter int K = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         vld_in,
    input  tsa_pkg::sq_t din,
    output logic         vld_out,
    output tsa_pkg::sq_t dout
);
    import tsa_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

    logic [SQ_W-1:0] trial;
    sq_t             cell_next;
    sq_t             cell_reg;
    logic            vld_reg;

    always_comb
    begin
        trial          = din.res + BIT;
        cell_next.flat = din.flat;
        cell_next.sx   = din.sx;
        if (din.n >= trial)
        begin
            cell_next.n   = din.n - trial;
            cell_next.res = (din.res >> 1) + BIT;
        end
        else
        begin
            cell_next.n   = din.n;
            cell_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            cell_reg <= cell_next;
    end

    assign vld_out = vld_reg;
    assign dout    = cell_reg;

endmodule

// ===== rtl/core/tsa_renorm.sv =====
// Aligns spacing and magnitude so the larger reaches bit 56 before CORDIC
module tsa_renorm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        vld_in,
    input  logic                        flat,
    input  logic [tsa_pkg::XS_W-1:0]    sx,
    input  logic [tsa_pkg::ROOT_W-1:0]  root,
    output logic                        vld_out,
    output tsa_pkg::cr_t                dout
);
    import tsa_pkg::*;

    logic [5:0]        msb_next, sh;
    logic [XS_W-1:0]   r1_x_reg;
    logic [ROOT_W-1:0] r1_y_reg;
    logic [5:0]        r1_msb_reg;
    logic              r1_flat_reg, r1_vld_reg;
    cr_t               r2_reg;
    logic              r2_vld_reg;

    assign msb_next = lead_one(64'(sx) | 64'(root));
    assign sh       = 6'(ALIGN_MSB) - r1_msb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            r1_vld_reg <= vld_in;
            r2_vld_reg <= r1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_x_reg    <= sx;
            r1_y_reg    <= root;
            r1_msb_reg  <= msb_next;
            r1_flat_reg <= flat;

            r2_reg.flat <= r1_flat_reg;
            r2_reg.x    <= $signed(CW'(r1_x_reg) << sh);
            r2_reg.y    <= $signed(CW'(r1_y_reg) << sh);
            r2_reg.z    <= '0;
        end
    end

    assign vld_out = r2_vld_reg;
    assign dout    = r2_reg;

endmodule

// ===== rtl/core/tsa_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation with its angle table entry
module tsa_cordic_cell #(
    parameter int I = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         vld_in,
    input  tsa_pkg::cr_t din,
    output logic         vld_out,
    output tsa_pkg::cr_t dout
);
    import tsa_pkg::*;

    localparam logic signed [ZW-1:0] ANG = $signed(ATAN_TAB[I]);

    logic signed [CW-1:0] xs, ys;
    cr_t                  cell_next;
    cr_t                  cell_reg;
    logic                 vld_reg;

    always_comb
    begin
        xs             = din.x >>> I;
        ys             = din.y >>> I;
        cell_next.flat = din.flat;
        if (!din.y[CW-1])
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
            cell_next.z = din.z + ANG;
        end
        else
        begin
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
            cell_next.z = din.z - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            cell_reg <= cell_next;
    end

    assign vld_out = vld_reg;
    assign dout    = cell_reg;

endmodule

// ===== rtl/core/terrain_slope_angle_core.sv =====
// Throughput: one item per cycle; the whole chain moves together and halts
// only while the output register holds an item under stall.
// Stages: 5 front, 31 square-root cells, 2 alignment, CORDIC cells, 1 output.
// Reset clears all valid bits and sets sample_distance to 256.
module terrain_slope_angle_core #(
    parameter int HEIGHT_BITS   = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [HEIGHT_BITS-1:0] height_left,
    input  logic signed [HEIGHT_BITS-1:0] height_right,
    input  logic signed [HEIGHT_BITS-1:0] height_down,
    input  logic signed [HEIGHT_BITS-1:0] height_up,
    input  logic                          cfg_we,
    input  logic [tsa_pkg::SD_W-1:0]      cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tsa_pkg::ANGLE_W-1:0]   slope_angle
);
    import tsa_pkg::*;

    logic              adv;
    logic [SD_W-1:0]   sample_distance_reg;
    logic              front_vld;
    front_t            front_out;

    sq_t               sq_pipe [ROOT_W+1];
    logic              sq_vld  [ROOT_W+1];

    cr_t               cr_pipe [CORDIC_STAGES+1];
    logic              cr_vld  [CORDIC_STAGES+1];

    cr_t               fin;
    logic [ZW-1:0]     z_round;
    logic [15:0]       ang_raw;
    logic [ANGLE_W-1:0] angle_next;
    logic              out_valid_reg;
    logic [ANGLE_W-1:0] slope_angle_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_distance_reg <= SD_RESET;
        else if (cfg_we)
            sample_distance_reg <= cfg_wdata;
    end

    tsa_front #(
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .vld_in         (in_valid),
        .height_left    (height_left),
        .height_right   (height_right),
        .height_down    (height_down),
        .height_up      (height_up),
        .sample_distance(sample_distance_reg),
        .vld_out        (front_vld),
        .dout           (front_out)
    );

    assign sq_vld[0]       = front_vld;
    assign sq_pipe[0].flat = front_out.flat;
    assign sq_pipe[0].sx   = front_out.sx;
    assign sq_pipe[0].n    = SQ_W'(front_out.sum);
    assign sq_pipe[0].res  = '0;

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        tsa_sqrt_cell #(
            .K(ROOT_W - 1 - j)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .vld_in (sq_vld[j]),
            .din    (sq_pipe[j]),
            .vld_out(sq_vld[j+1]),
            .dout   (sq_pipe[j+1])
        );
    end

    tsa_renorm u_renorm (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .vld_in (sq_vld[ROOT_W]),
        .flat   (sq_pipe[ROOT_W].flat),
        .sx     (sq_pipe[ROOT_W].sx),
        .root   (sq_pipe[ROOT_W].res[ROOT_W-1:0]),
        .vld_out(cr_vld[0]),
        .dout   (cr_pipe[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        tsa_cordic_cell #(
            .I(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .vld_in (cr_vld[i]),
            .din    (cr_pipe[i]),
            .vld_out(cr_vld[i+1]),
            .dout   (cr_pipe[i+1])
        );
    end

    // round to 14 fraction bits and clamp to 0..pi/2
    always_comb
    begin
        fin     = cr_pipe[CORDIC_STAGES];
        z_round = fin.z + ZW'(32'h8000);
        ang_raw = z_round[ZW-1:16];
        if (fin.flat || fin.z[ZW-1])
            angle_next = '0;
        else if (ang_raw > 16'(ANGLE_MAX))
            angle_next = ANGLE_MAX;
        else
            angle_next = ang_raw[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cr_vld[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            slope_angle_reg <= angle_next;
    end

    assign out_valid   = out_valid_reg;
    assign slope_angle = slope_angle_reg;

endmodule

// ===== rtl/core/tsa_checker.sv =====
// Port-level checks for the terrain slope angle core, with its bind
`include "assert_macros.svh"

module tsa_port_checks (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tsa_pkg::ANGLE_W-1:0] slope_angle
);
    import tsa_pkg::*;

    `TSA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
    `TSA_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(slope_angle))
    `TSA_ASSERT(a_angle_range, out_valid |-> slope_angle <= ANGLE_MAX)
    `TSA_ASSERT_NEVER(a_stall_cause, in_stall && !(out_valid && out_stall))

endmodule

bind terrain_slope_angle_core tsa_port_checks u_tsa_port_checks (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slope_angle(slope_angle)
);
